// ===== src/sjpg_pkg.sv =====
package sjpg_pkg;

    // timing constants
    localparam int unsigned TICKS_PER_MS = 1000;
    localparam int          PRESC_W      = 10;
    localparam int          MS_W         = 11;
    localparam int          ELAPSED_W    = 21;
    localparam int          SPEED_W      = 7;
    localparam int          COOL_W       = 10;
    localparam int          THR_W        = 7;
    localparam int          JOY_W        = 8;
    localparam int          QUO_W        = 23;
    localparam int          REM_W        = SPEED_W + 1;
    localparam int          BIT_IDX_W    = $clog2(QUO_W);
    localparam int          CFG_IDX_W    = 2;
    localparam int          CFG_DATA_W   = COOL_W;

    localparam logic [MS_W-1:0]      MS_SAT          = {MS_W{1'b1}};
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT     = {ELAPSED_W{1'b1}};
    localparam logic [QUO_W-1:0]     HALF_PERIOD_NUM = QUO_W'(5000000);
    localparam logic [PRESC_W-1:0]   PRESC_WRAP      = PRESC_W'(TICKS_PER_MS);
    localparam logic [SPEED_W-1:0]   SPEED_TOP       = {SPEED_W{1'b1}};
    localparam logic [SPEED_W-1:0]   SPEED_ONE       = SPEED_W'(1);

    // configuration register reset values
    localparam logic [COOL_W-1:0]  COOLDOWN_RST  = COOL_W'(150);
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = SPEED_W'(5);
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = SPEED_W'(100);
    localparam logic [THR_W-1:0]   THRESH_RST    = THR_W'(50);
    localparam logic [SPEED_W-1:0] SPEED_RST     = SPEED_W'(10);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOLDOWN  = 2'd0,
        CFG_MIN_SPEED = 2'd1,
        CFG_MAX_SPEED = 2'd2,
        CFG_THRESHOLD = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic                 load;
        logic                 div_step;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 finish;
    } dp_cmd_t;

endpackage

// ===== src/sjpg_ctrl.sv =====
module sjpg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sjpg_pkg::dp_cmd_t cmd
);
    import sjpg_pkg::*;

    state_t               state_reg, state_next;
    logic [BIT_IDX_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 m_valid_reg, m_valid_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.bit_idx  = bit_cnt_reg;
        cmd.finish   = 1'b0;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_IDX_W'(QUO_W - 1);
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/sjpg_datapath.sv =====
module sjpg_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sjpg_pkg::dp_cmd_t                  cmd,
    input  logic                               cfg_we,
    input  logic [sjpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sjpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_command_valid,
    input  logic signed [sjpg_pkg::JOY_W-1:0]  s_joy_y,
    input  logic                               s_button,
    output logic                               m_step_level,
    output logic                               m_motor_running,
    output logic [sjpg_pkg::SPEED_W-1:0]       m_speed_now,
    output logic                               m_status_changed
);
    import sjpg_pkg::*;

    // configuration registers
    logic [COOL_W-1:0]  cooldown_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [THR_W-1:0]   threshold_reg;

    // block state
    logic                 motor_on_reg, motor_on_next;
    logic                 prev_button_reg, prev_button_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic [MS_W-1:0]      ms_reg, ms_next;
    logic [PRESC_W-1:0]   presc_reg, presc_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 phase_reg, phase_next;
    logic                 changed_reg, changed_next;

    // divider
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   divisor;
    logic [ELAPSED_W-1:0] interval;

    // result register
    logic               out_step_reg, out_run_reg, out_chg_reg;
    logic [SPEED_W-1:0] out_speed_reg;

    // item update helpers
    logic [PRESC_W-1:0]   presc_inc;
    logic                 presc_wrap;
    logic [MS_W-1:0]      ms_adv;
    logic                 btn_rise;
    logic                 cool_ok;
    logic signed [JOY_W:0] joy_ext;
    logic signed [JOY_W:0] thr_pos;
    logic                 go_up;
    logic                 go_down;
    logic                 step_hit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cooldown_reg  <= COOLDOWN_RST;
            min_speed_reg <= MIN_SPEED_RST;
            max_speed_reg <= MAX_SPEED_RST;
            threshold_reg <= THRESH_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_COOLDOWN:  cooldown_reg  <= cfg_wdata;
                CFG_MIN_SPEED: min_speed_reg <= cfg_wdata[SPEED_W-1:0];
                CFG_MAX_SPEED: max_speed_reg <= cfg_wdata[SPEED_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // time advance and command on item load
    always_comb begin
        presc_inc  = presc_reg + 1'b1;
        presc_wrap = (presc_inc >= PRESC_WRAP);
        ms_adv     = (presc_wrap && ms_reg < MS_SAT) ? ms_reg + 1'b1 : ms_reg;
        btn_rise   = s_command_valid && s_button && !prev_button_reg;
        cool_ok    = ms_adv > {1'b0, cooldown_reg};
        joy_ext    = {s_joy_y[JOY_W-1], s_joy_y};
        thr_pos    = {2'b00, threshold_reg};
        go_up      = s_command_valid && cool_ok && (joy_ext > thr_pos)
                     && (speed_reg < max_speed_reg) && (speed_reg < SPEED_TOP);
        go_down    = s_command_valid && cool_ok && !go_up && (joy_ext < -thr_pos)
                     && (speed_reg > min_speed_reg) && (speed_reg > SPEED_ONE);
    end

    // divider step, interval clamp and toggle decision
    always_comb begin
        divisor   = {1'b0, (speed_reg == '0) ? SPEED_ONE : speed_reg};
        rem_shift = {rem_reg[REM_W-2:0], HALF_PERIOD_NUM[cmd.bit_idx]};
        interval  = (quo_reg > QUO_W'(ELAPSED_SAT)) ? ELAPSED_SAT
                                                    : quo_reg[ELAPSED_W-1:0];
        step_hit  = elapsed_reg >= interval;
    end

    // next state
    always_comb begin
        motor_on_next    = motor_on_reg;
        prev_button_next = prev_button_reg;
        speed_next       = speed_reg;
        ms_next          = ms_reg;
        presc_next       = presc_reg;
        elapsed_next     = elapsed_reg;
        phase_next       = phase_reg;
        changed_next     = changed_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        if (cmd.load) begin
            presc_next       = presc_wrap ? '0 : presc_inc;
            elapsed_next     = (elapsed_reg < ELAPSED_SAT) ? elapsed_reg + 1'b1
                                                           : elapsed_reg;
            motor_on_next    = motor_on_reg ^ btn_rise;
            prev_button_next = s_command_valid ? s_button : prev_button_reg;
            ms_next          = (go_up || go_down) ? '0 : ms_adv;
            if (go_up) begin
                speed_next = speed_reg + 1'b1;
            end else if (go_down) begin
                speed_next = speed_reg - 1'b1;
            end
            changed_next = btn_rise || go_up || go_down;
            rem_next     = '0;
            quo_next     = '0;
        end
        if (cmd.div_step) begin
            if (rem_shift >= divisor) begin
                rem_next = rem_shift - divisor;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            if (motor_on_reg) begin
                if (step_hit) begin
                    elapsed_next = '0;
                    phase_next   = !phase_reg;
                end
            end else begin
                phase_next = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_on_reg    <= 1'b0;
            prev_button_reg <= 1'b0;
            speed_reg       <= SPEED_RST;
            ms_reg          <= '0;
            presc_reg       <= '0;
            elapsed_reg     <= '0;
            phase_reg       <= 1'b0;
            changed_reg     <= 1'b0;
        end else begin
            motor_on_reg    <= motor_on_next;
            prev_button_reg <= prev_button_next;
            speed_reg       <= speed_next;
            ms_reg          <= ms_next;
            presc_reg       <= presc_next;
            elapsed_reg     <= elapsed_next;
            phase_reg       <= phase_next;
            changed_reg     <= changed_next;
        end
    end

    // divider registers and result payload
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.finish) begin
            out_step_reg  <= motor_on_reg & phase_next;
            out_run_reg   <= motor_on_reg;
            out_speed_reg <= speed_reg;
            out_chg_reg   <= changed_reg;
        end
    end

    assign m_step_level     = out_step_reg;
    assign m_motor_running  = out_run_reg;
    assign m_speed_now      = out_speed_reg;
    assign m_status_changed = out_chg_reg;

endmodule

// ===== src/stepper_jog_pulse_generator_top.sv =====
// channel | direction | signals                                    | handshake
// input   | in        | s_command_valid, s_joy_y, s_button         | s_valid / s_ready
// result  | out       | m_step_level, m_motor_running, m_speed_now,| m_valid / m_ready
//         |           | m_status_changed                           |
// config  | in        | cfg_index, cfg_wdata                       | cfg_we
//
// each transaction runs a load step, the bit-serial divider that derives the
// half period from the speed and a finish step; no new input is taken until
// the finish step is done. synchronous active-low reset of the control, state
// and config registers, no clearing pass; divider and output regs are not reset.
// a stalled result holds in the output register; the finish step waits for it.
module stepper_jog_pulse_generator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sjpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sjpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command_valid,
    input  logic signed [sjpg_pkg::JOY_W-1:0]  s_joy_y,
    input  logic                               s_button,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_step_level,
    output logic                               m_motor_running,
    output logic [sjpg_pkg::SPEED_W-1:0]       m_speed_now,
    output logic                               m_status_changed
);
    import sjpg_pkg::*;

    dp_cmd_t cmd;

    // controller
    sjpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath
    sjpg_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_command_valid  (s_command_valid),
        .s_joy_y          (s_joy_y),
        .s_button         (s_button),
        .m_step_level     (m_step_level),
        .m_motor_running  (m_motor_running),
        .m_speed_now      (m_speed_now),
        .m_status_changed (m_status_changed)
    );

endmodule

// ===== src/sjpg_checker.sv =====
module sjpg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_step_level,
    input logic                         m_motor_running,
    input logic [sjpg_pkg::SPEED_W-1:0] m_speed_now
);
    import sjpg_pkg::*;

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one transaction in flight at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // step output only while motor runs
    a_step_needs_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_step_level || m_motor_running))
        else $error("step high with motor off");

    // speed never reaches zero
    a_speed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed_now != '0))
        else $error("speed is zero");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_speed_now)
                                   && $stable(m_step_level)))
        else $error("stalled result changed");

endmodule

bind stepper_jog_pulse_generator_top sjpg_checker u_sjpg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_step_level    (m_step_level),
    .m_motor_running (m_motor_running),
    .m_speed_now     (m_speed_now)
);

// ===== sim/tb_stepper_jog_pulse_generator_top.sv =====
`timescale 1ns / 100ps

module tb_stepper_jog_pulse_generator_top;
    import sjpg_pkg::*;

    localparam int          US_PER_MS      = 1000;
    localparam int unsigned HALF_PERIOD_US = 5000000;
    localparam int unsigned ELAPSED_CEIL   = 2097151;
    localparam int unsigned SPEED_CEIL     = 127;
    localparam int          ITEM_CYCLES    = 25;
    localparam int          WATCHDOG_LIMIT = 4000;

    // one tick worth of pulse generator outputs
    typedef struct packed {
        logic               step;
        logic               running;
        logic [SPEED_W-1:0] speed;
        logic               changed;
    } jog_outcome_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    cfg_idx_t                  cfg_index = CFG_COOLDOWN;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_command_valid = 1'b0;
    logic signed [JOY_W-1:0]   s_joy_y = '0;
    logic                      s_button = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_step_level;
    logic                      m_motor_running;
    logic [SPEED_W-1:0]        m_speed_now;
    logic                      m_status_changed;

    // expected pulse generator state and registers
    logic                      exp_motor_on;
    logic                      exp_prev_button;
    logic [SPEED_W-1:0]        exp_speed;
    logic [MS_W-1:0]           exp_ms_count;
    logic [PRESC_W-1:0]        exp_prescale;
    logic [ELAPSED_W-1:0]      exp_elapsed;
    logic                      exp_phase;
    logic [COOL_W-1:0]         exp_cooldown;
    logic [SPEED_W-1:0]        exp_min_speed;
    logic [SPEED_W-1:0]        exp_max_speed;
    logic [THR_W-1:0]          exp_threshold;

    jog_outcome_t              tick_outcomes_q[$];
    jog_outcome_t              want;
    int                        mismatches = 0;
    int                        quiet_cycles = 0;
    int                        tx_idle_pct = 0;
    int                        rx_stall_pct = 0;
    int                        rx_hold_left = 0;

    stepper_jog_pulse_generator_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command_valid  (s_command_valid),
        .s_joy_y          (s_joy_y),
        .s_button         (s_button),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_level     (m_step_level),
        .m_motor_running  (m_motor_running),
        .m_speed_now      (m_speed_now),
        .m_status_changed (m_status_changed)
    );

    always #2 aclk = ~aclk;

    // advance the expected state by one microsecond tick
    function automatic jog_outcome_t jog_tick_outcome(input logic cmd_valid,
                                                      input logic signed [JOY_W-1:0] joy,
                                                      input logic btn);
        jog_outcome_t res;
        int           thr;
        int unsigned  half_period;
        logic         chg;
        chg = 1'b0;
        thr = int'(exp_threshold);

        // time base first
        if (int'(exp_prescale) + 1 >= US_PER_MS) begin
            exp_prescale = '0;
            if (exp_ms_count != '1) exp_ms_count++;
        end else begin
            exp_prescale++;
        end
        if (exp_elapsed != '1) exp_elapsed++;

        // button edge and joystick speed change
        if (cmd_valid) begin
            if (btn && !exp_prev_button) begin
                exp_motor_on = !exp_motor_on;
                chg = 1'b1;
            end
            exp_prev_button = btn;
            if (exp_ms_count > exp_cooldown) begin
                if (int'(joy) > thr && exp_speed < exp_max_speed && exp_speed < SPEED_CEIL) begin
                    exp_speed++;
                    exp_ms_count = '0;
                    chg = 1'b1;
                end else if (int'(joy) < -thr && exp_speed > exp_min_speed && exp_speed > 1) begin
                    exp_speed--;
                    exp_ms_count = '0;
                    chg = 1'b1;
                end
            end
        end

        // step level with the updated speed
        if (exp_motor_on) begin
            half_period = HALF_PERIOD_US / ((exp_speed == 0) ? 1 : exp_speed);
            if (half_period > ELAPSED_CEIL) half_period = ELAPSED_CEIL;
            if (exp_elapsed >= half_period) begin
                exp_elapsed = '0;
                exp_phase = !exp_phase;
            end
        end else begin
            exp_phase = 1'b0;
        end

        res.step    = exp_motor_on & exp_phase;
        res.running = exp_motor_on;
        res.speed   = exp_speed;
        res.changed = chg;
        return res;
    endfunction

    // model update, result check and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            exp_motor_on    = 1'b0;
            exp_prev_button = 1'b0;
            exp_speed       = 10;
            exp_ms_count    = '0;
            exp_prescale    = '0;
            exp_elapsed     = '0;
            exp_phase       = 1'b0;
            exp_cooldown    = 150;
            exp_min_speed   = 5;
            exp_max_speed   = 100;
            exp_threshold   = 50;
            tick_outcomes_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COOLDOWN:  exp_cooldown  = cfg_wdata[COOL_W-1:0];
                    CFG_MIN_SPEED: exp_min_speed = cfg_wdata[SPEED_W-1:0];
                    CFG_MAX_SPEED: exp_max_speed = cfg_wdata[SPEED_W-1:0];
                    CFG_THRESHOLD: exp_threshold = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (tick_outcomes_q.size() == 0) begin
                    $error("result transaction with no tick pending");
                    mismatches++;
                end else begin
                    want = tick_outcomes_q.pop_front();
                    if (m_step_level !== want.step) begin
                        $error("step_level: expected %0d, got %0d", want.step, m_step_level);
                        mismatches++;
                    end
                    if (m_motor_running !== want.running) begin
                        $error("motor_running: expected %0d, got %0d",
                               want.running, m_motor_running);
                        mismatches++;
                    end
                    if (m_speed_now !== want.speed) begin
                        $error("speed_now: expected %0d, got %0d", want.speed, m_speed_now);
                        mismatches++;
                    end
                    if (m_status_changed !== want.changed) begin
                        $error("status_changed: expected %0d, got %0d",
                               want.changed, m_status_changed);
                        mismatches++;
                    end
                end
            end

            if (s_valid && s_ready)
                tick_outcomes_q.push_back(jog_tick_outcome(s_command_valid, s_joy_y, s_button));

            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_stepper_jog_pulse_generator_top: FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure, with an optional long hold-off
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // offer one tick transaction and wait until it is taken
    task automatic send_tick(input logic cmd_valid, input logic signed [JOY_W-1:0] joy,
                             input logic btn);
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command_valid <= cmd_valid;
        s_joy_y         <= joy;
        s_button        <= btn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait for every pending result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tick_outcomes_q.size() != 0) @(negedge aclk);
    endtask

    // register write, random bits above a narrow register's width
    task automatic write_reg(input cfg_idx_t idx, input int value);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        if (idx == CFG_COOLDOWN)
            word = CFG_DATA_W'(value);
        else
            word[SPEED_W-1:0] = SPEED_W'(value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // joystick values, biased toward the threshold boundaries
    function automatic logic signed [JOY_W-1:0] pick_joy();
        int thr;
        thr = int'(exp_threshold);
        case ($urandom_range(3))
            0:       return JOY_W'($urandom);
            1:       return JOY_W'($urandom_range(1) ? thr : -thr);
            2:       return JOY_W'($urandom_range(1) ? thr + 1 : -thr - 1);
            default: return JOY_W'(int'($urandom_range(200)) - 100);
        endcase
    endfunction

    // mostly clean press and release patterns, some noise ticks
    task automatic run_random(input int count);
        logic btn_level;
        int   kind;
        btn_level = 1'b0;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                if ($urandom_range(4) == 0) btn_level = !btn_level;
                send_tick(1'b1, pick_joy(), btn_level);
            end else if (kind < 85) begin
                send_tick(1'b0, JOY_W'($urandom), 1'($urandom));
            end else begin
                send_tick(1'b1, pick_joy(), 1'($urandom));
            end
        end
    endtask

    // field extremes, ignored commands, button edges, cooldown blocking
    task automatic test_directed();
        set_idling(0, 0);
        send_tick(1'b0, 127, 1'b1);
        send_tick(1'b1, 0, 1'b1);
        send_tick(1'b1, -128, 1'b1);
        send_tick(1'b1, 127, 1'b0);
        send_tick(1'b0, -128, 1'b1);
        send_tick(1'b1, 100, 1'b1);
        send_tick(1'b1, -100, 1'b0);
        send_tick(1'b1, 51, 1'b1);
        send_tick(1'b1, -51, 1'b1);
        send_tick(1'b1, 50, 1'b0);
        send_tick(1'b1, -50, 1'b0);
        send_tick(1'b1, 1, 1'b0);
        send_tick(1'b1, -1, 1'b0);
        send_tick(1'b0, 0, 1'b0);
        send_tick(1'b1, 0, 1'b1);
        send_tick(1'b1, 0, 1'b0);
        drain_results();
    endtask

    // limits set outside the range, long result hold-off fills the block
    task automatic test_locked_speed();
        set_idling(0, 0);
        write_reg(CFG_COOLDOWN, 1023);
        write_reg(CFG_MIN_SPEED, 127);
        write_reg(CFG_MAX_SPEED, 0);
        write_reg(CFG_THRESHOLD, 100);
        run_random(150);
        rx_hold_left = 300;
        run_random(350);
        drain_results();
    endtask

    // no cooldown and widest limits, speed free to move either way
    task automatic test_free_speed();
        set_idling(54, 0);
        write_reg(CFG_COOLDOWN, 0);
        write_reg(CFG_MIN_SPEED, 1);
        write_reg(CFG_MAX_SPEED, 127);
        write_reg(CFG_THRESHOLD, 0);
        run_random(550);
        drain_results();
    endtask

    // lowering pinned at the current speed, top threshold
    task automatic test_blocked_lowering();
        set_idling(0, 54);
        write_reg(CFG_COOLDOWN, 1);
        write_reg(CFG_MIN_SPEED, int'(exp_speed));
        write_reg(CFG_MAX_SPEED, 1);
        write_reg(CFG_THRESHOLD, 127);
        run_random(175);
        drain_results();
        run_random(175);
        drain_results();
    endtask

    // raising capped at the current speed, lowering open down to one
    task automatic test_capped_raise();
        set_idling(7, 7);
        write_reg(CFG_COOLDOWN, 0);
        write_reg(CFG_MIN_SPEED, 0);
        write_reg(CFG_MAX_SPEED, int'(exp_speed));
        write_reg(CFG_THRESHOLD, 50);
        run_random(700);
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_locked_speed();
        test_free_speed();
        test_blocked_lowering();
        test_capped_raise();

        repeat (2 * ITEM_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_stepper_jog_pulse_generator_top: PASS");
        else
            $display("tb_stepper_jog_pulse_generator_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sjpg_pkg.sv
src/sjpg_ctrl.sv
src/sjpg_datapath.sv
src/stepper_jog_pulse_generator_top.sv
src/sjpg_checker.sv
sim/tb_stepper_jog_pulse_generator_top.sv
